// ===== sv/rmth_pkg.sv =====
// shared types and constants for the running median unit
// no dependencies
package rmth_pkg;

   localparam int MAX_ITEMS_DEF = 1024;
   localparam int SAMPLE_W      = 32;
   localparam int MEDIAN_W      = 33;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PUSH_INIT,
      OP_PUSH_STEP,
      OP_POP_TOP,
      OP_POP_LAST,
      OP_POP_SIFT0,
      OP_POP_L,
      OP_POP_R,
      OP_SWITCH,
      OP_MED_READ,
      OP_MED_CALC,
      OP_RSP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic push_done;
      logic l_out;
      logic pop_done_r;
      logic lower_heavy;
      logic upper_heavy;
   } dp_stat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_P0, S_P1, S_BAL, S_D0, S_D1, S_D2, S_D3, S_D4,
      S_SW, S_M0, S_M1, S_OUT
   } state_type;

endpackage

// ===== sv/rmth_dp.sv =====
// datapath: two heap memories, sift index registers, counts and median
// depends on rmth_pkg
module rmth_dp import rmth_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [MEDIAN_W-1:0] rsp_median,
   output logic                       rsp_full
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW:0] MAX_C = (CW+1)'(MAX_ITEMS);

   logic signed [SAMPLE_W-1:0] mem_lo [MAX_ITEMS];
   logic signed [SAMPLE_W-1:0] mem_up [MAX_ITEMS];
   logic signed [SAMPLE_W-1:0] q_lo_ff, q_up_ff, q;

   logic [AW-1:0] raddr, waddr;
   logic          we;
   logic signed [SAMPLE_W-1:0] wdata;

   logic [CW-1:0] cnt_lo_ff, cnt_lo_in, cnt_up_ff, cnt_up_in, n;
   logic [AW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in, top_ff, top_in, bval_ff, bval_in;
   logic sel_ff, sel_in; // 1 = upper (min) heap
   logic full_ff, full_in;
   logic signed [MEDIAN_W-1:0] med_ff, med_in, rsp_med_ff, rsp_med_in;
   logic rsp_full_ff, rsp_full_in;

   logic [AW:0] l_idx, r_idx;
   logic [AW-1:0] par, par2;
   logic swap, better_lv, better_rb;
   logic [AW-1:0] fbest;
   logic signed [SAMPLE_W-1:0] fbval;

   function automatic logic better(input logic is_min,
                                   input logic signed [SAMPLE_W-1:0] a,
                                   input logic signed [SAMPLE_W-1:0] b);
      better = is_min ? (a < b) : (a > b);
   endfunction

   always_ff @(posedge clock) begin
      if (we && sel_ff) mem_up[waddr] <= wdata;
      if (we && !sel_ff) mem_lo[waddr] <= wdata;
      q_lo_ff <= mem_lo[raddr];
      q_up_ff <= mem_up[raddr];
   end

   assign q     = sel_ff ? q_up_ff : q_lo_ff;
   assign n     = sel_ff ? cnt_up_ff : cnt_lo_ff;
   assign l_idx = {idx_ff, 1'b1};
   assign r_idx = l_idx + (AW+1)'(1);
   assign par   = (idx_ff - AW'(1)) >> 1;
   assign par2  = (par - AW'(1)) >> 1;
   assign swap  = better(sel_ff, val_ff, q);
   assign better_lv = ({1'b0, l_idx} < (AW+2)'(n)) && better(sel_ff, q, val_ff);
   assign better_rb = ({1'b0, r_idx} < (AW+2)'(n)) && better(sel_ff, q, bval_ff);
   assign fbest = better_rb ? r_idx[AW-1:0] : best_ff;
   assign fbval = better_rb ? q : bval_ff;

   always_comb begin
      stat.full        = full_ff;
      stat.push_done   = (idx_ff == '0) || !swap;
      stat.l_out       = ({1'b0, l_idx} >= (AW+2)'(n));
      stat.pop_done_r  = (fbest == idx_ff);
      stat.lower_heavy = (CW+1)'(cnt_lo_ff) > (CW+1)'(cnt_up_ff) + (CW+1)'(1);
      stat.upper_heavy = (CW+1)'(cnt_up_ff) > (CW+1)'(cnt_lo_ff) + (CW+1)'(1);
   end

   always_comb begin
      raddr = '0; waddr = idx_ff; we = 1'b0; wdata = val_ff;
      cnt_lo_in = cnt_lo_ff; cnt_up_in = cnt_up_ff;
      idx_in = idx_ff; best_in = best_ff; val_in = val_ff; top_in = top_ff;
      bval_in = bval_ff; sel_in = sel_ff; full_in = full_ff; med_in = med_ff;
      rsp_med_in = rsp_med_ff; rsp_full_in = rsp_full_ff;
      case (cmd.op)
         OP_LOAD: begin
            val_in  = sample;
            full_in = ((CW+1)'(cnt_lo_ff) + (CW+1)'(cnt_up_ff)) >= MAX_C;
            sel_in  = $signed({sample, 1'b0}) >= med_ff;
         end
         OP_PUSH_INIT: begin
            idx_in = n[AW-1:0];
            raddr  = (n[AW-1:0] - AW'(1)) >> 1;
            if (sel_ff) cnt_up_in = cnt_up_ff + CW'(1);
            else        cnt_lo_in = cnt_lo_ff + CW'(1);
         end
         OP_PUSH_STEP: begin
            we = 1'b1;
            if (!((idx_ff == '0) || !swap)) begin
               wdata  = q;
               idx_in = par;
               raddr  = par2;
            end
         end
         OP_POP_TOP: begin
            raddr = '0;
            if (sel_ff) cnt_up_in = cnt_up_ff - CW'(1);
            else        cnt_lo_in = cnt_lo_ff - CW'(1);
         end
         OP_POP_LAST: begin
            top_in = q;
            raddr  = n[AW-1:0];
         end
         OP_POP_SIFT0: begin
            val_in = q;
            idx_in = '0;
            raddr  = AW'(1);
         end
         OP_POP_L: begin
            raddr = r_idx[AW-1:0];
            if (better_lv) begin
               bval_in = q; best_in = l_idx[AW-1:0];
            end else begin
               bval_in = val_ff; best_in = idx_ff;
            end
            if ({1'b0, l_idx} >= (AW+2)'(n)) we = 1'b1;
         end
         OP_POP_R: begin
            we = 1'b1;
            if (fbest != idx_ff) begin
               wdata  = fbval;
               idx_in = fbest;
               raddr  = AW'({fbest, 1'b1});
            end
         end
         OP_SWITCH: begin
            val_in = top_ff;
            sel_in = ~sel_ff;
         end
         OP_MED_READ: raddr = '0;
         OP_MED_CALC: begin
            if (cnt_up_ff > cnt_lo_ff)      med_in = {q_up_ff, 1'b0};
            else if (cnt_lo_ff > cnt_up_ff) med_in = {q_lo_ff, 1'b0};
            else if (cnt_lo_ff != '0)
               med_in = MEDIAN_W'(q_up_ff) + MEDIAN_W'(q_lo_ff);
         end
         OP_RSP: begin
            rsp_med_in  = med_ff;
            rsp_full_in = full_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_lo_ff <= '0;
         cnt_up_ff <= '0;
         med_ff    <= '0;
      end else begin
         cnt_lo_ff <= cnt_lo_in;
         cnt_up_ff <= cnt_up_in;
         med_ff    <= med_in;
      end
      idx_ff <= idx_in; best_ff <= best_in; val_ff <= val_in; top_ff <= top_in;
      bval_ff <= bval_in; sel_ff <= sel_in; full_ff <= full_in;
      rsp_med_ff <= rsp_med_in; rsp_full_ff <= rsp_full_in;
   end

   assign rsp_median = rsp_med_ff;
   assign rsp_full   = rsp_full_ff;

endmodule

// ===== sv/rmth_ctrl.sv =====
// controller state machine sequencing inserts, removals and median update
// depends on rmth_pkg
module rmth_ctrl import rmth_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   state_type state_ff, state_in;
   logic phase_ff, phase_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op = OP_NONE;
      req_tready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.op = OP_LOAD; phase_in = 1'b0; state_in = S_CHK;
         end
         S_CHK: state_in = stat.full ? S_OUT : S_P0;
         S_P0: begin
            cmd.op = OP_PUSH_INIT; state_in = S_P1;
         end
         S_P1: begin
            cmd.op = OP_PUSH_STEP;
            if (stat.push_done) state_in = phase_ff ? S_M0 : S_BAL;
         end
         S_BAL: state_in = (stat.lower_heavy || stat.upper_heavy) ? S_D0 : S_M0;
         S_D0: begin
            cmd.op = OP_POP_TOP; state_in = S_D1;
         end
         S_D1: begin
            cmd.op = OP_POP_LAST; state_in = S_D2;
         end
         S_D2: begin
            cmd.op = OP_POP_SIFT0; state_in = S_D3;
         end
         S_D3: begin
            cmd.op = OP_POP_L;
            state_in = stat.l_out ? S_SW : S_D4;
         end
         S_D4: begin
            cmd.op = OP_POP_R;
            state_in = stat.pop_done_r ? S_SW : S_D3;
         end
         S_SW: begin
            cmd.op = OP_SWITCH; phase_in = 1'b1; state_in = S_P0;
         end
         S_M0: begin
            cmd.op = OP_MED_READ; state_in = S_M1;
         end
         S_M1: begin
            cmd.op = OP_MED_CALC; state_in = S_OUT;
         end
         S_OUT: if (!rsp_valid_ff || rsp_tready) begin
            cmd.op = OP_RSP; rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/running_median_two_heaps_unit.sv =====
// running median over two heaps: each beat runs an insert with sift-up, then, when needed,
// a move between heaps (a sift-down on one heap and a second sift-up on the other)
// and a median refresh; the heap depth sets how long a beat takes
// one beat in service at a time; a finished beat waits in the output register
// synchronous active-high reset clears counts, median and control; heaps need no clearing
// depends on rmth_pkg, rmth_ctrl, rmth_dp
module running_median_two_heaps_unit import rmth_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [32:0] median_x2, [39:33] zero
   output logic [0:0]  rsp_tuser    // [0] full_res
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic signed [MEDIAN_W-1:0] median;
   logic full;

   // sequencer: insert, optional rebalance move, median refresh; all are skipped when full
   rmth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // heap memories and arithmetic
   rmth_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .sample     (req_tdata),
      .rsp_median (median),
      .rsp_full   (full)
   );

   // pack the result beat
   assign rsp_tdata = {7'd0, median};
   assign rsp_tuser = full;

endmodule
